[hw/rtl/hrp_pkg.sv]
// Shared types, codes and constants for the HTTP request header parser.
`default_nettype none

package hrp_pkg;

  localparam int FIELD_BUFFER_BYTES_DFLT = 512;
  localparam int ARG_SLOTS_DFLT = 16;

  localparam int LEN_LIMIT_W = 9;
  localparam int ARG_LIMIT_W = 5;
  localparam int CFG_DATA_W = 9;
  localparam int CFG_INDEX_W = 4;
  localparam int SLOT_W = 5;

  localparam logic [CFG_INDEX_W-1:0] REG_FIELD_LEN_LIMIT = 4'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_ARG_LIMIT = 4'd1;

  localparam logic [LEN_LIMIT_W-1:0] FIELD_LEN_LIMIT_RST = 9'd511;
  localparam logic [ARG_LIMIT_W-1:0] ARG_LIMIT_RST = 5'd16;

  typedef enum logic [3:0] {
    PH_METHOD    = 4'd0,
    PH_PATH      = 4'd1,
    PH_VERSION   = 4'd2,
    PH_ARG_NAME  = 4'd3,
    PH_ARG_VALUE = 4'd4,
    PH_LINE_LF   = 4'd5,
    PH_HDR_NAME  = 4'd6,
    PH_HDR_VALUE = 4'd7,
    PH_HDR_LF    = 4'd8,
    PH_END_LF    = 4'd9
  } phase_t;

  localparam logic [2:0] CL_DELIM     = 3'd0;
  localparam logic [2:0] CL_METHOD    = 3'd1;
  localparam logic [2:0] CL_PATH      = 3'd2;
  localparam logic [2:0] CL_ARG_NAME  = 3'd3;
  localparam logic [2:0] CL_ARG_VALUE = 3'd4;
  localparam logic [2:0] CL_VERSION   = 3'd5;
  localparam logic [2:0] CL_HDR_NAME  = 3'd6;
  localparam logic [2:0] CL_HDR_VALUE = 3'd7;

  localparam logic [1:0] ST_PARSING = 2'd0;
  localparam logic [1:0] ST_DONE    = 2'd1;
  localparam logic [1:0] ST_BAD     = 2'd2;
  localparam logic [1:0] ST_EOS     = 2'd3;

  localparam logic [2:0] ERR_NONE      = 3'd0;
  localparam logic [2:0] ERR_LINE_CRLF = 3'd1;
  localparam logic [2:0] ERR_TOO_LONG  = 3'd2;
  localparam logic [2:0] ERR_TOO_MANY  = 3'd3;
  localparam logic [2:0] ERR_VERSION   = 3'd4;
  localparam logic [2:0] ERR_NO_LF     = 3'd5;

  localparam logic [7:0] CH_CR    = 8'h0d;
  localparam logic [7:0] CH_LF    = 8'h0a;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_QUEST = 8'h3f;
  localparam logic [7:0] CH_EQUAL = 8'h3d;
  localparam logic [7:0] CH_AMP   = 8'h26;
  localparam logic [7:0] CH_COLON = 8'h3a;
  localparam logic [7:0] CH_G     = 8'h47;
  localparam logic [7:0] CH_E     = 8'h45;
  localparam logic [7:0] CH_T     = 8'h54;
  localparam logic [7:0] CH_H     = 8'h48;
  localparam logic [7:0] CH_P     = 8'h50;
  localparam logic [7:0] CH_SLASH = 8'h2f;
  localparam logic [7:0] CH_ONE   = 8'h31;
  localparam logic [7:0] CH_DOT   = 8'h2e;
  localparam logic [7:0] CH_ZERO  = 8'h30;

  typedef struct packed {
    logic [2:0]        byte_class;
    logic [7:0]        byte_out;
    logic [2:0]        closes_field;
    logic [SLOT_W-1:0] arg_slot;
    logic              method_get;
    logic [1:0]        parse_status;
    logic [2:0]        error_cause;
  } result_t;

  function automatic logic is_version_char(input logic [7:0] c);
    return (c == CH_H) || (c == CH_T) || (c == CH_P) || (c == CH_SLASH) ||
           (c == CH_ONE) || (c == CH_DOT) || (c == CH_ZERO);
  endfunction

endpackage

`default_nettype wire

[hw/rtl/http_request_header_parser_unit.sv]
// Top level of the HTTP request header parser: input and result registers, configuration.
//
// Usage: request bytes enter on the input channel (in_valid/in_ready), one byte per
// transfer, with end_of_stream marking a closed connection. Every input transfer gives
// exactly one result transfer on the output channel (out_valid/out_ready) carrying the
// byte's class, the field it closes, the argument slot, the GET flag and the status.
// The byte sits in the input register while the classification logic runs, and the
// result register is written from it when the result register is empty or being taken.
// Throughput is one byte per cycle while the receiver takes every result; the parser
// state update between the two registers is the only loop. When the receiver stalls,
// the result register holds its transfer and the input register keeps one more byte;
// in_ready drops once both are full and returns in the cycle the result is taken.
// Reset empties both registers, puts the parser at the start of a request and sets
// field_len_limit to 511 and arg_limit to 16. Configuration writes take effect at once;
// the user must make them only while no byte is in flight; the block itself does not
// enforce this. After a completed request, a bad request or end of stream the parser
// starts over with the next byte.
`default_nettype none

module http_request_header_parser_unit #(
  parameter int FIELD_BUFFER_BYTES = hrp_pkg::FIELD_BUFFER_BYTES_DFLT,
  parameter int ARG_SLOTS = hrp_pkg::ARG_SLOTS_DFLT
) (
  input  wire logic                             clk,
  input  wire logic                             rst,
  input  wire logic                             cfg_write_en,
  input  wire logic [hrp_pkg::CFG_INDEX_W-1:0]  cfg_index,
  input  wire logic [hrp_pkg::CFG_DATA_W-1:0]   cfg_data,
  input  wire logic                             in_valid,
  output logic                                  in_ready,
  input  wire logic [7:0]                       data_byte,
  input  wire logic                             end_of_stream,
  output logic                                  out_valid,
  input  wire logic                             out_ready,
  output logic [2:0]                            byte_class,
  output logic [7:0]                            byte_out,
  output logic [2:0]                            closes_field,
  output logic [hrp_pkg::SLOT_W-1:0]            arg_slot,
  output logic                                  method_get,
  output logic [1:0]                            parse_status,
  output logic [2:0]                            error_cause
);
  import hrp_pkg::*;

  logic [LEN_LIMIT_W-1:0] field_len_limit;
  logic [ARG_LIMIT_W-1:0] arg_limit;
  logic                   in_full;
  logic [7:0]             in_byte;
  logic                   in_eos;
  logic                   fire;
  result_t                result_next;
  result_t                result;

  assign fire = in_full && (!out_valid || out_ready);
  assign in_ready = !in_full || fire;

  always_ff @(posedge clk) begin
    if (rst) begin
      field_len_limit <= FIELD_LEN_LIMIT_RST;
      arg_limit <= ARG_LIMIT_RST;
    end else if (cfg_write_en) begin
      if (cfg_index == REG_FIELD_LEN_LIMIT) begin
        field_len_limit <= cfg_data[LEN_LIMIT_W-1:0];
      end else if (cfg_index == REG_ARG_LIMIT) begin
        arg_limit <= cfg_data[ARG_LIMIT_W-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      in_full <= 1'b0;
    end else if (in_ready) begin
      in_full <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      in_byte <= data_byte;
      in_eos <= end_of_stream;
    end
  end

  hrp_core #(
    .FIELD_BUFFER_BYTES(FIELD_BUFFER_BYTES),
    .ARG_SLOTS(ARG_SLOTS)
  ) u_core (
    .clk(clk),
    .rst(rst),
    .fire(fire),
    .data_byte(in_byte),
    .end_of_stream(in_eos),
    .field_len_limit(field_len_limit),
    .arg_limit(arg_limit),
    .result(result_next)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (fire) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      result <= result_next;
    end
  end

  assign byte_class = result.byte_class;
  assign byte_out = result.byte_out;
  assign closes_field = result.closes_field;
  assign arg_slot = result.arg_slot;
  assign method_get = result.method_get;
  assign parse_status = result.parse_status;
  assign error_cause = result.error_cause;

endmodule

`default_nettype wire

[hw/rtl/hrp_core.sv]
// Parser state registers and the per-byte classification and state update.
`default_nettype none

module hrp_core #(
  parameter int FIELD_BUFFER_BYTES = hrp_pkg::FIELD_BUFFER_BYTES_DFLT,
  parameter int ARG_SLOTS = hrp_pkg::ARG_SLOTS_DFLT
) (
  input  wire logic                             clk,
  input  wire logic                             rst,
  input  wire logic                             fire,
  input  wire logic [7:0]                       data_byte,
  input  wire logic                             end_of_stream,
  input  wire logic [hrp_pkg::LEN_LIMIT_W-1:0]  field_len_limit,
  input  wire logic [hrp_pkg::ARG_LIMIT_W-1:0]  arg_limit,
  output hrp_pkg::result_t                      result
);
  import hrp_pkg::*;

  localparam int LEN_CAP = (FIELD_BUFFER_BYTES - 1 < 511) ? FIELD_BUFFER_BYTES - 1 : 511;
  localparam int LEN_W = $clog2(LEN_CAP + 1);
  localparam int ARG_REG_MAX = (1 << ARG_LIMIT_W) - 1;
  localparam int ARG_CAP = (ARG_SLOTS < ARG_REG_MAX) ? ARG_SLOTS : ARG_REG_MAX;
  localparam int CNT_W = $clog2(ARG_CAP + 1);

  phase_t           phase, phase_next;
  logic [LEN_W-1:0] field_length, field_length_next;
  logic [CNT_W-1:0] arg_count, arg_count_next;
  logic             get_match, get_match_next;
  logic             method_is_get, method_is_get_next;

  logic [2:0] cls, closes, field_cls, cause;
  logic [1:0] status;
  logic       is_crlf, len_ok, args_full, get_ok;

  always_ff @(posedge clk) begin
    if (rst) begin
      phase <= PH_METHOD;
      field_length <= '0;
      arg_count <= '0;
      get_match <= 1'b1;
      method_is_get <= 1'b0;
    end else if (fire) begin
      phase <= phase_next;
      field_length <= field_length_next;
      arg_count <= arg_count_next;
      get_match <= get_match_next;
      method_is_get <= method_is_get_next;
    end
  end

  assign is_crlf = (data_byte == CH_CR) || (data_byte == CH_LF);
  assign len_ok = (LEN_LIMIT_W'(field_length) < field_len_limit) &&
                  (field_length < LEN_W'(LEN_CAP));
  assign args_full = (ARG_LIMIT_W'(arg_count) >= arg_limit) ||
                     (arg_count >= CNT_W'(ARG_CAP));
  assign get_ok = ((field_length == LEN_W'(0)) && (data_byte == CH_G)) ||
                  ((field_length == LEN_W'(1)) && (data_byte == CH_E)) ||
                  ((field_length == LEN_W'(2)) && (data_byte == CH_T));

  always_comb begin
    phase_next = phase;
    field_length_next = field_length;
    arg_count_next = arg_count;
    get_match_next = get_match;
    method_is_get_next = method_is_get;
    cls = CL_DELIM;
    closes = CL_DELIM;
    field_cls = CL_DELIM;
    status = ST_PARSING;
    cause = ERR_NONE;

    if (end_of_stream) begin
      status = ST_EOS;
    end else begin
      case (phase)
        PH_PATH: begin
          if ((data_byte == CH_SPACE) || (data_byte == CH_QUEST)) begin
            closes = CL_PATH;
            field_length_next = '0;
            phase_next = (data_byte == CH_SPACE) ? PH_VERSION : PH_ARG_NAME;
          end else if (is_crlf) begin
            cause = ERR_LINE_CRLF;
          end else begin
            field_cls = CL_PATH;
          end
        end
        PH_ARG_NAME: begin
          if ((data_byte == CH_SPACE) || (data_byte == CH_EQUAL) ||
              (data_byte == CH_AMP)) begin
            if (args_full) begin
              cause = ERR_TOO_MANY;
            end else begin
              closes = CL_ARG_NAME;
              field_length_next = '0;
              if (data_byte != CH_EQUAL) begin
                arg_count_next = arg_count + CNT_W'(1);
              end
              if (data_byte == CH_SPACE) begin
                phase_next = PH_VERSION;
              end else if (data_byte == CH_EQUAL) begin
                phase_next = PH_ARG_VALUE;
              end else begin
                phase_next = PH_ARG_NAME;
              end
            end
          end else if (is_crlf) begin
            cause = ERR_LINE_CRLF;
          end else begin
            field_cls = CL_ARG_NAME;
          end
        end
        PH_ARG_VALUE: begin
          if ((data_byte == CH_SPACE) || (data_byte == CH_AMP)) begin
            closes = CL_ARG_VALUE;
            field_length_next = '0;
            arg_count_next = arg_count + CNT_W'(1);
            phase_next = (data_byte == CH_SPACE) ? PH_VERSION : PH_ARG_NAME;
          end else if (is_crlf) begin
            cause = ERR_LINE_CRLF;
          end else begin
            field_cls = CL_ARG_VALUE;
          end
        end
        PH_VERSION: begin
          if (is_crlf) begin
            closes = CL_VERSION;
            field_length_next = '0;
            phase_next = (data_byte == CH_LF) ? PH_HDR_NAME : PH_LINE_LF;
          end else if (is_version_char(data_byte)) begin
            cls = CL_VERSION;
          end else begin
            cause = ERR_VERSION;
          end
        end
        PH_LINE_LF, PH_HDR_LF: begin
          if (data_byte == CH_LF) begin
            field_length_next = '0;
            phase_next = PH_HDR_NAME;
          end else begin
            cause = ERR_NO_LF;
          end
        end
        PH_END_LF: begin
          if (data_byte == CH_LF) begin
            status = ST_DONE;
          end else begin
            cause = ERR_NO_LF;
          end
        end
        PH_HDR_NAME: begin
          if ((data_byte == CH_LF) && (field_length == '0)) begin
            status = ST_DONE;
          end else if ((data_byte == CH_CR) && (field_length == '0)) begin
            phase_next = PH_END_LF;
          end else if (data_byte == CH_COLON) begin
            closes = CL_HDR_NAME;
            field_length_next = '0;
            phase_next = PH_HDR_VALUE;
          end else begin
            field_cls = CL_HDR_NAME;
          end
        end
        PH_HDR_VALUE: begin
          if (is_crlf) begin
            closes = CL_HDR_VALUE;
            field_length_next = '0;
            phase_next = (data_byte == CH_CR) ? PH_HDR_LF : PH_HDR_NAME;
          end else begin
            field_cls = CL_HDR_VALUE;
          end
        end
        default: begin
          phase_next = PH_METHOD;
          if (data_byte == CH_SPACE) begin
            closes = CL_METHOD;
            method_is_get_next = get_match && (field_length == LEN_W'(3));
            field_length_next = '0;
            phase_next = PH_PATH;
          end else if (is_crlf) begin
            cause = ERR_LINE_CRLF;
          end else begin
            field_cls = CL_METHOD;
          end
        end
      endcase

      if (field_cls != CL_DELIM) begin
        if (len_ok) begin
          if ((field_cls == CL_METHOD) && !get_ok) begin
            get_match_next = 1'b0;
          end
          field_length_next = field_length + LEN_W'(1);
          cls = field_cls;
        end else begin
          cause = ERR_TOO_LONG;
        end
      end
      if (cause != ERR_NONE) begin
        status = ST_BAD;
        cls = CL_DELIM;
        closes = CL_DELIM;
      end
    end

    result.byte_class = cls;
    result.byte_out = end_of_stream ? 8'd0 : data_byte;
    result.closes_field = closes;
    result.arg_slot = SLOT_W'(arg_count);
    result.method_get = method_is_get_next;
    result.parse_status = status;
    result.error_cause = cause;

    if (status != ST_PARSING) begin
      phase_next = PH_METHOD;
      field_length_next = '0;
      arg_count_next = '0;
      get_match_next = 1'b1;
      method_is_get_next = 1'b0;
    end
  end

endmodule

`default_nettype wire

[bench/testbench.sv]
// Self-checking testbench for the HTTP request header parser with its own byte classifier.
`default_nettype none

module testbench;
  import hrp_pkg::*;

  localparam int CYCLE_LIMIT = 200000;
  localparam int DRAIN_CYCLES = 4;
  localparam int PHASE_BYTES = 150;
  localparam logic [CFG_INDEX_W-1:0] REG_UNUSED = 4'hf;

  typedef struct packed {
    logic       eos;
    logic [7:0] data;
  } stream_item_t;

  logic                   clk;
  logic                   rst = 1'b1;
  logic                   cfg_write_en = 1'b0;
  logic [CFG_INDEX_W-1:0] cfg_index = '0;
  logic [CFG_DATA_W-1:0]  cfg_data = '0;
  logic                   in_valid = 1'b0;
  logic                   in_ready;
  logic [7:0]             data_byte = '0;
  logic                   end_of_stream = 1'b0;
  logic                   out_valid;
  logic                   out_ready = 1'b0;
  logic [2:0]             byte_class;
  logic [7:0]             byte_out;
  logic [2:0]             closes_field;
  logic [SLOT_W-1:0]      arg_slot;
  logic                   method_get;
  logic [1:0]             parse_status;
  logic [2:0]             error_cause;

  phase_t       parse_phase;
  logic [8:0]   fld_len;
  logic [4:0]   arg_cnt;
  logic         get_ok;
  logic         is_get;
  logic [8:0]   len_lim;
  logic [4:0]   arg_lim;

  result_t      verdict_q[$];
  stream_item_t stream_q[$];
  result_t      want;
  int           idle_pct = 0;
  int           stall_pct = 0;
  int           bytes_sent = 0;
  int           mismatches = 0;
  int           cycle_count = 0;

  http_request_header_parser_unit dut (
    .clk(clk), .rst(rst),
    .cfg_write_en(cfg_write_en), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .in_valid(in_valid), .in_ready(in_ready),
    .data_byte(data_byte), .end_of_stream(end_of_stream),
    .out_valid(out_valid), .out_ready(out_ready),
    .byte_class(byte_class), .byte_out(byte_out), .closes_field(closes_field),
    .arg_slot(arg_slot), .method_get(method_get),
    .parse_status(parse_status), .error_cause(error_cause)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  function automatic void restart_parse();
    parse_phase = PH_METHOD;
    fld_len = '0;
    arg_cnt = '0;
    get_ok = 1'b1;
    is_get = 1'b0;
  endfunction

  function automatic result_t classify_byte(input logic [7:0] c, input logic eos);
    result_t    r;
    logic [2:0] fcls;
    logic [2:0] cause;
    logic       crlf;
    logic       full;
    logic [7:0] want_ch;
    r = '0;
    r.byte_out = c;
    r.arg_slot = arg_cnt;
    fcls = CL_DELIM;
    cause = ERR_NONE;
    crlf = (c == CH_CR) || (c == CH_LF);
    full = arg_cnt >= ((arg_lim < ARG_SLOTS_DFLT) ? arg_lim : ARG_SLOTS_DFLT);
    if (eos) begin
      r.byte_out = 8'h00;
      r.parse_status = ST_EOS;
    end else begin
      case (parse_phase)
        PH_PATH: begin
          if (c == CH_SPACE || c == CH_QUEST) begin
            r.closes_field = CL_PATH;
            fld_len = '0;
            parse_phase = (c == CH_SPACE) ? PH_VERSION : PH_ARG_NAME;
          end else if (crlf) begin
            cause = ERR_LINE_CRLF;
          end else begin
            fcls = CL_PATH;
          end
        end
        PH_ARG_NAME: begin
          if (c == CH_SPACE || c == CH_EQUAL || c == CH_AMP) begin
            if (full) begin
              cause = ERR_TOO_MANY;
            end else begin
              r.closes_field = CL_ARG_NAME;
              fld_len = '0;
              if (c != CH_EQUAL) arg_cnt = arg_cnt + 5'd1;
              if (c == CH_SPACE) parse_phase = PH_VERSION;
              else if (c == CH_EQUAL) parse_phase = PH_ARG_VALUE;
              else parse_phase = PH_ARG_NAME;
            end
          end else if (crlf) begin
            cause = ERR_LINE_CRLF;
          end else begin
            fcls = CL_ARG_NAME;
          end
        end
        PH_ARG_VALUE: begin
          if (c == CH_SPACE || c == CH_AMP) begin
            r.closes_field = CL_ARG_VALUE;
            fld_len = '0;
            arg_cnt = arg_cnt + 5'd1;
            parse_phase = (c == CH_SPACE) ? PH_VERSION : PH_ARG_NAME;
          end else if (crlf) begin
            cause = ERR_LINE_CRLF;
          end else begin
            fcls = CL_ARG_VALUE;
          end
        end
        PH_VERSION: begin
          if (crlf) begin
            r.closes_field = CL_VERSION;
            fld_len = '0;
            parse_phase = (c == CH_LF) ? PH_HDR_NAME : PH_LINE_LF;
          end else if (c == CH_H || c == CH_T || c == CH_P || c == CH_SLASH ||
                       c == CH_ONE || c == CH_DOT || c == CH_ZERO) begin
            r.byte_class = CL_VERSION;
          end else begin
            cause = ERR_VERSION;
          end
        end
        PH_LINE_LF, PH_HDR_LF: begin
          if (c == CH_LF) begin
            fld_len = '0;
            parse_phase = PH_HDR_NAME;
          end else begin
            cause = ERR_NO_LF;
          end
        end
        PH_END_LF: begin
          if (c == CH_LF) r.parse_status = ST_DONE;
          else cause = ERR_NO_LF;
        end
        PH_HDR_NAME: begin
          if (c == CH_LF && fld_len == 9'd0) begin
            r.parse_status = ST_DONE;
          end else if (c == CH_CR && fld_len == 9'd0) begin
            parse_phase = PH_END_LF;
          end else if (c == CH_COLON) begin
            r.closes_field = CL_HDR_NAME;
            fld_len = '0;
            parse_phase = PH_HDR_VALUE;
          end else begin
            fcls = CL_HDR_NAME;
          end
        end
        PH_HDR_VALUE: begin
          if (crlf) begin
            r.closes_field = CL_HDR_VALUE;
            fld_len = '0;
            parse_phase = (c == CH_CR) ? PH_HDR_LF : PH_HDR_NAME;
          end else begin
            fcls = CL_HDR_VALUE;
          end
        end
        default: begin
          parse_phase = PH_METHOD;
          if (c == CH_SPACE) begin
            r.closes_field = CL_METHOD;
            is_get = get_ok && (fld_len == 9'd3);
            fld_len = '0;
            parse_phase = PH_PATH;
          end else if (crlf) begin
            cause = ERR_LINE_CRLF;
          end else begin
            fcls = CL_METHOD;
          end
        end
      endcase
      if (fcls != CL_DELIM) begin
        if (fld_len < len_lim) begin
          if (fcls == CL_METHOD) begin
            case (fld_len)
              9'd0: want_ch = CH_G;
              9'd1: want_ch = CH_E;
              9'd2: want_ch = CH_T;
              default: want_ch = 8'h00;
            endcase
            if (fld_len >= 9'd3 || c != want_ch) get_ok = 1'b0;
          end
          fld_len = fld_len + 9'd1;
          r.byte_class = fcls;
        end else begin
          cause = ERR_TOO_LONG;
        end
      end
      if (cause != ERR_NONE) begin
        r.parse_status = ST_BAD;
        r.byte_class = CL_DELIM;
        r.closes_field = CL_DELIM;
      end
      r.error_cause = cause;
    end
    r.method_get = is_get;
    if (r.parse_status != ST_PARSING) restart_parse();
    return r;
  endfunction

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  always @(posedge clk) begin
    out_ready <= ($urandom_range(99, 0) >= stall_pct);
  end

  task automatic check_field(input string what, input int exp_v, input int act_v);
    if (exp_v != act_v) begin
      $display("%0t: %s expected %0d, got %0d", $time, what, exp_v, act_v);
      mismatches++;
    end
  endtask

  always @(posedge clk) begin
    if (!rst && out_valid && out_ready) begin
      if (verdict_q.size() == 0) begin
        $display("%0t: result transfer with none expected, got byte_out %0d",
                 $time, byte_out);
        mismatches++;
      end else begin
        want = verdict_q.pop_front();
        check_field("byte_class", want.byte_class, byte_class);
        check_field("byte_out", want.byte_out, byte_out);
        check_field("closes_field", want.closes_field, closes_field);
        check_field("arg_slot", want.arg_slot, arg_slot);
        check_field("method_get", want.method_get, method_get);
        check_field("parse_status", want.parse_status, parse_status);
        check_field("error_cause", want.error_cause, error_cause);
      end
    end
  end

  task automatic send_item(input logic [7:0] b, input logic eos);
    if (idle_pct != 0 && $urandom_range(99, 0) < idle_pct) begin
      in_valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99, 0) < idle_pct);
    end
    in_valid <= 1'b1;
    data_byte <= b;
    end_of_stream <= eos;
    do @(posedge clk); while (!in_ready);
    verdict_q.push_back(classify_byte(b, eos));
    bytes_sent++;
  endtask

  task automatic send_stream();
    stream_item_t it;
    while (stream_q.size() != 0) begin
      it = stream_q.pop_front();
      send_item(it.data, it.eos);
    end
  endtask

  task automatic drain_results();
    in_valid <= 1'b0;
    while (verdict_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic set_limit(input logic [CFG_INDEX_W-1:0] idx,
                           input logic [CFG_DATA_W-1:0] val);
    drain_results();
    cfg_write_en <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    cfg_write_en <= 1'b0;
    if (idx == REG_FIELD_LEN_LIMIT) len_lim = val[8:0];
    else if (idx == REG_ARG_LIMIT) arg_lim = val[4:0];
  endtask

  task automatic push_item(input logic eos, input logic [7:0] b);
    stream_item_t it;
    it.eos = eos;
    it.data = b;
    stream_q.push_back(it);
  endtask

  task automatic push_byte(input logic [7:0] b);
    push_item(1'b0, b);
  endtask

  task automatic push_text(input string s);
    int i;
    for (i = 0; i < s.len(); i++) push_byte(s[i]);
  endtask

  task automatic push_eol();
    if ($urandom_range(1, 0)) push_byte(CH_CR);
    push_byte(CH_LF);
  endtask

  // Text bytes avoid every delimiter; value bytes avoid only CR and LF.
  function automatic logic [7:0] field_byte(input logic text_only);
    logic [7:0] b;
    b = 8'($urandom_range(255, 0));
    while (b == CH_CR || b == CH_LF ||
           (text_only && (b == CH_SPACE || b == CH_QUEST || b == CH_EQUAL ||
                          b == CH_AMP || b == CH_COLON)))
      b = 8'($urandom_range(255, 0));
    return b;
  endfunction

  task automatic build_request();
    int         n;
    int         k;
    logic [7:0] b;
    if ($urandom_range(6, 0) != 0) push_text("GET");
    else repeat ($urandom_range(4, 0)) push_byte(field_byte(1'b1));
    push_byte(CH_SPACE);
    push_byte(CH_SLASH);
    repeat ($urandom_range(5, 0)) push_byte(field_byte(1'b1));
    if ($urandom_range(1, 0)) begin
      push_byte(CH_QUEST);
      n = $urandom_range(4, 0);
      for (k = 0; k < n; k++) begin
        repeat ($urandom_range(3, 0)) push_byte(field_byte(1'b1));
        if ($urandom_range(1, 0)) begin
          push_byte(CH_EQUAL);
          repeat ($urandom_range(3, 0)) push_byte(field_byte(1'b1));
        end
        if (k < n - 1) push_byte(CH_AMP);
      end
    end
    push_byte(CH_SPACE);
    if ($urandom_range(3, 0) != 0) begin
      push_text("HTTP/1.0");
    end else begin
      repeat ($urandom_range(4, 0)) begin
        case ($urandom_range(6, 0))
          0: b = CH_H;
          1: b = CH_T;
          2: b = CH_P;
          3: b = CH_SLASH;
          4: b = CH_ONE;
          5: b = CH_DOT;
          default: b = CH_ZERO;
        endcase
        push_byte(b);
      end
    end
    push_eol();
    repeat ($urandom_range(3, 0)) begin
      push_byte(field_byte(1'b1));
      if ($urandom_range(7, 0) == 0) push_byte($urandom_range(1, 0) ? CH_CR : CH_LF);
      repeat ($urandom_range(4, 0)) push_byte(field_byte(1'b1));
      push_byte(CH_COLON);
      repeat ($urandom_range(6, 0)) push_byte(field_byte(1'b0));
      push_eol();
    end
    push_eol();
    // Now and then damage the request: a stray byte, or a connection that drops.
    n = stream_q.size();
    case ($urandom_range(9, 0))
      0: begin
        b = 8'($urandom_range(255, 0));
        stream_q[$urandom_range(n - 1, 0)].data = b;
      end
      1: begin
        k = $urandom_range(n - 1, 0);
        while (stream_q.size() > k) stream_q.delete(stream_q.size() - 1);
        b = 8'($urandom_range(255, 0));
        push_item(1'b1, b);
      end
      default: ;
    endcase
  endtask

  task automatic build_noise();
    logic [7:0] b;
    repeat ($urandom_range(6, 1)) begin
      b = 8'($urandom_range(255, 0));
      push_item($urandom_range(7, 0) == 0, b);
    end
  endtask

  task automatic test_request_flow();
    push_text("GET /?a=b&c H");
    push_byte(CH_LF);
    push_text("N");
    push_byte(CH_CR);
    push_text(":v");
    push_byte(CH_CR);
    push_byte(CH_LF);
    push_byte(CH_LF);
    send_stream();
  endtask

  task automatic test_stream_errors();
    push_item(1'b1, 8'ha5);
    push_byte(CH_CR);
    push_byte(CH_SPACE);
    push_byte(8'hff);
    push_byte(CH_SPACE);
    push_byte(8'h00);
    push_text(" / H");
    push_byte(CH_CR);
    push_text("X");
    send_stream();
  endtask

  task automatic test_limits();
    set_limit(REG_FIELD_LEN_LIMIT, 9'd0);
    set_limit(REG_ARG_LIMIT, 9'd0);
    push_text("G");
    push_text(" /?&");
    send_stream();
    set_limit(REG_FIELD_LEN_LIMIT, 9'd1);
    set_limit(REG_ARG_LIMIT, 9'd1);
    set_limit(REG_UNUSED, 9'd0);
    push_text("GG");
    push_text(" /?a&b&");
    send_stream();
  endtask

  task automatic test_random_traffic(input int idle, input int stall,
                                     input logic [8:0] len, input logic [4:0] args);
    int start;
    bit first;
    set_limit(REG_FIELD_LEN_LIMIT, len);
    set_limit(REG_ARG_LIMIT, {4'b0, args});
    idle_pct = idle;
    stall_pct = stall;
    start = bytes_sent;
    first = 1'b1;
    while (bytes_sent - start < PHASE_BYTES) begin
      if ($urandom_range(7, 0) == 0) build_noise();
      else build_request();
      send_stream();
      if (first) begin
        drain_results();
        first = 1'b0;
      end
    end
  endtask

  initial begin
    restart_parse();
    len_lim = FIELD_LEN_LIMIT_RST;
    arg_lim = ARG_LIMIT_RST;
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    test_request_flow();
    test_stream_errors();
    test_limits();
    test_random_traffic(0, 0, 9'd511, 5'd16);
    test_random_traffic(60, 0, 9'($urandom_range(12, 3)), 5'($urandom_range(4, 0)));
    test_random_traffic(0, 60, 9'($urandom_range(511, 1)), 5'($urandom_range(16, 0)));
    test_random_traffic(9, 9, 9'd511, 5'd31);
    drain_results();
    if (mismatches == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule

`default_nettype wire

[http_request_header_parser_unit.f]
hw/rtl/hrp_pkg.sv
hw/rtl/hrp_core.sv
hw/rtl/http_request_header_parser_unit.sv
bench/testbench.sv
